/* sv/calendar_date_counter_unit_defines.svh */
// Assertion macros for the calendar date counter.
`ifndef CALENDAR_DATE_COUNTER_UNIT_DEFINES_SVH
`define CALENDAR_DATE_COUNTER_UNIT_DEFINES_SVH

// Checked at every rising edge, ignored while reset is high.
`define CDC_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define CDC_ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/cdc_pkg.sv */
// Constants, codes and tables for the calendar date counter.
package cdc_pkg;

   localparam logic [1:0] CMD_LOAD = 2'd0;
   localparam logic [1:0] CMD_INC  = 2'd1;
   localparam logic [1:0] CMD_DEC  = 2'd2;
   localparam logic [1:0] CMD_DIFF = 2'd3;

   localparam logic [13:0] YEAR_RESET = 14'd1970;
   localparam logic [13:0] YEAR_MAX   = 14'd16383;
   localparam logic [6:0]  CENT_RESET = 7'd70;
   localparam logic [1:0]  QUAD_RESET = 2'd3;
   localparam logic [6:0]  CENT_OF_YEAR_MAX = 7'd83;
   localparam logic [1:0]  QUAD_OF_YEAR_MAX = 2'd3;
   localparam logic [3:0]  WEEKDAY_RESET = 4'd4;
   localparam logic [3:0]  WEEKDAY_UNKNOWN = 4'hF;
   localparam logic [3:0]  WEEKDAY_LAST = 4'd6;

   // day numbers of 1970-01-01, 0000-01-01 and 16383-12-31
   localparam logic [22:0] DN_RESET = 23'd865565;
   localparam logic [22:0] DN_FIRST = 23'd146037;
   localparam logic [22:0] DN_LAST  = 23'd6130169;

   // floor(x / 100) = (x * RECIP_100) >> RECIP_SHIFT for x below 43690
   localparam logic [12:0] RECIP_100   = 13'd5243;
   localparam int          RECIP_SHIFT = 19;

   localparam logic [22:0] DIFF_POS_SAT = 23'h3FFFFF;
   localparam logic [22:0] DIFF_NEG_SAT = 23'h400000;

   function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
      logic [4:0] d;
      unique case (m)
         4'd2: d = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
         default: d = 5'd31;
      endcase
      return d;
   endfunction

   // day of year counted from March 1st at the first day of month m
   function automatic logic [8:0] month_offset(input logic [3:0] m);
      logic [8:0] o;
      unique case (m)
         4'd1:  o = 9'd306;
         4'd2:  o = 9'd337;
         4'd4:  o = 9'd31;
         4'd5:  o = 9'd61;
         4'd6:  o = 9'd92;
         4'd7:  o = 9'd122;
         4'd8:  o = 9'd153;
         4'd9:  o = 9'd184;
         4'd10: o = 9'd214;
         4'd11: o = 9'd245;
         4'd12: o = 9'd275;
         default: o = 9'd0;
      endcase
      return o;
   endfunction

endpackage

/* sv/calendar_date_counter_unit.sv */
// Top level of the calendar date counter: date registers and command pipeline.
//
// Usage:
//   req channel: one beat per command. req_tuser carries the command code
//   (load, increment, decrement, days since), req_tdata the argument date.
//   rsp channel: exactly one beat per command, in order, carrying the stored
//   date after the command and, for days since, the signed day count from the
//   argument date to the stored date (zero for other commands).
//   Pipeline: an accepted req beat passes the input register, divide-by-100
//   multiply stage, day-number stage and result register before its rsp beat.
//   Throughput: one command per cycle unless rsp stalls; the stored date is read
//   and written only in the last stage, so back-to-back commands see each other's
//   effect. Each stage holds its beat while the next one is full, so a stalled rsp
//   side fills the pipeline bubbles before req_tready drops; the result
//   register holds a waiting beat unchanged.
//   Reset: synchronous, active high; clears all stage valids and sets the
//   date to Thursday 1970-01-01.
`include "calendar_date_counter_unit_defines.svh"

module calendar_date_counter_unit
   import cdc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [13:0] arg_year, [17:14] arg_month, [22:18] arg_day, [26:23] arg_weekday
   input  logic [31:0] req_tdata,
   // [1:0] command
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [13:0] cur_year, [17:14] cur_month, [22:18] cur_day, [26:23] cur_weekday,
   // [49:27] day_difference
   output logic [55:0] rsp_tdata
);

   // stage enables
   logic en_i, en_a, en_b, en_r;

   // input register
   logic        i_valid_ff;
   logic [1:0]  i_cmd_ff;
   logic [13:0] i_year_ff;
   logic [3:0]  i_month_ff;
   logic [4:0]  i_day_ff;
   logic [3:0]  i_wday_ff;

   // stage a
   logic        a_valid_ff;
   logic [1:0]  a_cmd_ff;
   logic [13:0] a_year_ff;
   logic [3:0]  a_month_ff;
   logic [4:0]  a_day_ff;
   logic [3:0]  a_wday_ff;
   logic [7:0]  a_qy_ff;
   logic [14:0] a_yy_ff;
   logic [7:0]  a_qyy_ff;
   logic [8:0]  a_off_ff;
   logic [3:0]  a_month_in;
   logic [3:0]  a_wday_in;
   logic [26:0] a_prod_y;
   logic [27:0] a_prod_yy;
   logic [14:0] a_yy_in;

   // stage b
   logic        b_valid_ff;
   logic [1:0]  b_cmd_ff;
   logic [13:0] b_year_ff;
   logic [3:0]  b_month_ff;
   logic [4:0]  b_day_ff;
   logic [3:0]  b_wday_ff;
   logic [6:0]  b_cent_ff;
   logic [1:0]  b_quad_ff;
   logic [22:0] b_dn_ff;
   logic [13:0] b_cent_wide;
   logic [6:0]  b_cent_in;
   logic        b_leap;
   logic [4:0]  b_lim;
   logic [4:0]  b_day_in;
   logic [22:0] b_dn_in;

   // stored date
   logic [13:0] yr_ff, yr_in;
   logic [3:0]  mo_ff, mo_in;
   logic [4:0]  dy_ff, dy_in;
   logic [3:0]  wd_ff, wd_in;
   logic [6:0]  cent_ff, cent_in;
   logic [1:0]  quad_ff, quad_in;
   logic [22:0] dn_ff, dn_in;
   logic        st_leap;
   logic [4:0]  st_lim;
   logic [3:0]  st_prev_mo;
   logic [23:0] diff_wide;
   logic [22:0] diff_in;

   // result register
   logic        rsp_valid_ff;
   logic [55:0] rsp_data_ff;
   logic        update;

   assign en_r = !rsp_valid_ff || rsp_tready;
   assign en_b = !b_valid_ff || en_r;
   assign en_a = !a_valid_ff || en_b;
   assign en_i = !i_valid_ff || en_a;
   assign req_tready = en_i;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign update = b_valid_ff && en_r;

   always_ff @(posedge clock) begin
      if (reset) begin
         i_valid_ff <= 1'b0;
      end else if (en_i) begin
         i_valid_ff <= req_tvalid;
      end
      if (en_i) begin
         i_cmd_ff   <= req_tuser;
         i_year_ff  <= req_tdata[13:0];
         i_month_ff <= req_tdata[17:14];
         i_day_ff   <= req_tdata[22:18];
         i_wday_ff  <= req_tdata[26:23];
      end
   end

   // stage a: clamp month, check weekday, split off year / 100 by reciprocal multiply
   always_comb begin
      if (i_month_ff == 4'd0) begin
         a_month_in = 4'd1;
      end else if (i_month_ff > 4'd12) begin
         a_month_in = 4'd12;
      end else begin
         a_month_in = i_month_ff;
      end
      if ((!i_wday_ff[3] && i_wday_ff != 4'd7) || i_wday_ff == WEEKDAY_UNKNOWN) begin
         a_wday_in = i_wday_ff;
      end else begin
         a_wday_in = WEEKDAY_UNKNOWN;
      end
      a_yy_in = {1'b0, i_year_ff} + 15'd400 - ((a_month_in <= 4'd2) ? 15'd1 : 15'd0);
      a_prod_y = 27'(i_year_ff) * 27'(RECIP_100);
      a_prod_yy = 28'(a_yy_in) * 28'(RECIP_100);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en_a) begin
         a_valid_ff <= i_valid_ff;
      end
      if (en_a) begin
         a_cmd_ff   <= i_cmd_ff;
         a_year_ff  <= i_year_ff;
         a_month_ff <= a_month_in;
         a_day_ff   <= i_day_ff;
         a_wday_ff  <= a_wday_in;
         a_qy_ff    <= a_prod_y[RECIP_SHIFT +: 8];
         a_yy_ff    <= a_yy_in;
         a_qyy_ff   <= a_prod_yy[RECIP_SHIFT +: 8];
         a_off_ff   <= month_offset(a_month_in);
      end
   end

   // stage b: leap test, clamp day, day number of the argument date
   always_comb begin
      b_cent_wide = a_year_ff - 14'(a_qy_ff) * 14'd100;
      b_cent_in = b_cent_wide[6:0];
      b_leap = (a_year_ff[1:0] == 2'd0) && (b_cent_in != 7'd0 || a_qy_ff[1:0] == 2'd0);
      b_lim = month_days(a_month_ff, b_leap);
      if (a_day_ff == 5'd0) begin
         b_day_in = 5'd1;
      end else if (a_day_ff > b_lim) begin
         b_day_in = b_lim;
      end else begin
         b_day_in = a_day_ff;
      end
      b_dn_in = 23'(a_yy_ff) * 23'd365 + 23'(a_yy_ff[14:2]) - 23'(a_qyy_ff)
              + 23'(a_qyy_ff[7:2]) + 23'(a_off_ff) + 23'(b_day_in) - 23'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (en_b) begin
         b_valid_ff <= a_valid_ff;
      end
      if (en_b) begin
         b_cmd_ff   <= a_cmd_ff;
         b_year_ff  <= a_year_ff;
         b_month_ff <= a_month_ff;
         b_day_ff   <= b_day_in;
         b_wday_ff  <= a_wday_ff;
         b_cent_ff  <= b_cent_in;
         b_quad_ff  <= a_qy_ff[1:0];
         b_dn_ff    <= b_dn_in;
      end
   end

   // last stage: apply the command to the stored date
   always_comb begin
      st_leap = (yr_ff[1:0] == 2'd0) && (cent_ff != 7'd0 || quad_ff == 2'd0);
      st_lim = month_days(mo_ff, st_leap);
      st_prev_mo = (mo_ff <= 4'd1) ? 4'd12 : mo_ff - 4'd1;
      yr_in = yr_ff;
      mo_in = mo_ff;
      dy_in = dy_ff;
      wd_in = wd_ff;
      cent_in = cent_ff;
      quad_in = quad_ff;
      dn_in = dn_ff;
      diff_wide = {1'b0, dn_ff} - {1'b0, b_dn_ff};
      diff_in = 23'd0;
      case (b_cmd_ff)
         CMD_LOAD: begin
            yr_in = b_year_ff;
            mo_in = b_month_ff;
            dy_in = b_day_ff;
            wd_in = b_wday_ff;
            cent_in = b_cent_ff;
            quad_in = b_quad_ff;
            dn_in = b_dn_ff;
         end
         CMD_INC: begin
            dn_in = dn_ff + 23'd1;
            if (dy_ff >= st_lim) begin
               dy_in = 5'd1;
               if (mo_ff >= 4'd12) begin
                  mo_in = 4'd1;
                  yr_in = yr_ff + 14'd1;
                  if (yr_ff == YEAR_MAX) begin
                     cent_in = 7'd0;
                     quad_in = 2'd0;
                     dn_in = DN_FIRST;
                  end else if (cent_ff == 7'd99) begin
                     cent_in = 7'd0;
                     quad_in = quad_ff + 2'd1;
                  end else begin
                     cent_in = cent_ff + 7'd1;
                  end
               end else begin
                  mo_in = mo_ff + 4'd1;
               end
            end else begin
               dy_in = dy_ff + 5'd1;
            end
            if (!wd_ff[3]) begin
               wd_in = (wd_ff >= WEEKDAY_LAST) ? 4'd0 : wd_ff + 4'd1;
            end
         end
         CMD_DEC: begin
            dn_in = dn_ff - 23'd1;
            if (dy_ff <= 5'd1) begin
               mo_in = st_prev_mo;
               dy_in = month_days(st_prev_mo, st_leap);
               if (mo_ff <= 4'd1) begin
                  yr_in = yr_ff - 14'd1;
                  if (yr_ff == 14'd0) begin
                     cent_in = CENT_OF_YEAR_MAX;
                     quad_in = QUAD_OF_YEAR_MAX;
                     dn_in = DN_LAST;
                  end else if (cent_ff == 7'd0) begin
                     cent_in = 7'd99;
                     quad_in = quad_ff - 2'd1;
                  end else begin
                     cent_in = cent_ff - 7'd1;
                  end
               end
            end else begin
               dy_in = dy_ff - 5'd1;
            end
            if (!wd_ff[3]) begin
               wd_in = (wd_ff == 4'd0) ? WEEKDAY_LAST : wd_ff - 4'd1;
            end
         end
         default: begin
            if (diff_wide[23] != diff_wide[22]) begin
               diff_in = diff_wide[23] ? DIFF_NEG_SAT : DIFF_POS_SAT;
            end else begin
               diff_in = diff_wide[22:0];
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         yr_ff <= YEAR_RESET;
         mo_ff <= 4'd1;
         dy_ff <= 5'd1;
         wd_ff <= WEEKDAY_RESET;
         cent_ff <= CENT_RESET;
         quad_ff <= QUAD_RESET;
         dn_ff <= DN_RESET;
      end else if (update) begin
         yr_ff <= yr_in;
         mo_ff <= mo_in;
         dy_ff <= dy_in;
         wd_ff <= wd_in;
         cent_ff <= cent_in;
         quad_ff <= quad_in;
         dn_ff <= dn_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en_r) begin
         rsp_valid_ff <= b_valid_ff;
      end
      if (en_r) begin
         rsp_data_ff <= {6'd0, diff_in, wd_in, dy_in, mo_in, yr_in};
      end
   end

   `CDC_ASSERT_RST(a_month_range, clock, reset, mo_ff >= 4'd1 && mo_ff <= 4'd12, "stored month out of range")
   `CDC_ASSERT_RST(a_day_range, clock, reset, dy_ff >= 5'd1 && dy_ff <= st_lim, "stored day beyond month length")
   `CDC_ASSERT_RST(a_weekday_range, clock, reset, wd_ff == WEEKDAY_UNKNOWN || wd_ff <= WEEKDAY_LAST, "stored weekday out of range")
   `CDC_ASSERT_RST(a_state_hold, clock, reset, !update |=> $stable(dn_ff) && $stable(yr_ff), "date changed without a beat")

endmodule

/* dv/tb.sv */
// Self-checking testbench for the calendar date counter: directed table, then random commands.
module tb;
   import cdc_pkg::*;

   localparam int RANDOM_CMDS = 650;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_BEAT   = 140;
   localparam int HOLD_CYCLES = 80;

   typedef struct packed {
      logic [13:0]        year;
      logic [3:0]         month;
      logic [4:0]         day;
      logic signed [3:0]  weekday;
      logic signed [22:0] diff;
   } cal_rsp_type;

   typedef struct {
      logic [1:0]  cmd;
      logic [13:0] y;
      logic [3:0]  m;
      logic [4:0]  d;
      logic [3:0]  w;
      bit          typed;
      cal_rsp_type expv;
   } cal_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;

   // stored date as the block should hold it
   logic [13:0]       cal_year = 14'd1970;
   logic [3:0]        cal_month = 4'd1;
   logic [4:0]        cal_day = 5'd1;
   logic signed [3:0] cal_wd = 4'sd4;

   cal_rsp_type pending_dates[$];
   cal_row_type dir_rows[$];
   int          cmds_sent = 0;
   int          rsp_beats = 0;
   int          failures = 0;
   int          cycle_count = 0;
   int          cmd_count[4] = '{0, 0, 0, 0};

   calendar_date_counter_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic bit leap_year(int y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
   endfunction

   function automatic int month_len(int m, int y);
      case (m)
         2: return leap_year(y) ? 29 : 28;
         4, 6, 9, 11: return 30;
         default: return 31;
      endcase
   endfunction

   // days counted from a fixed epoch with March as the first month
   function automatic longint day_index(int y, int m, int d);
      longint yy, mm, doy;
      yy = y + 400 - ((m <= 2) ? 1 : 0);
      mm = m + ((m > 2) ? -3 : 9);
      doy = (153 * mm + 2) / 5 + d - 1;
      return 365 * yy + yy / 4 - yy / 100 + yy / 400 + doy;
   endfunction

   function automatic cal_rsp_type apply_command(input logic [1:0] cmd, input logic [13:0] ay,
                                                 input logic [3:0] am_raw,
                                                 input logic [4:0] ad_raw,
                                                 input logic [3:0] aw_raw);
      int          am, ad, aw, lim;
      longint      span;
      cal_rsp_type r;
      am = (am_raw < 1) ? 1 : ((am_raw > 12) ? 12 : am_raw);
      lim = month_len(am, ay);
      ad = (ad_raw < 1) ? 1 : ((ad_raw > lim) ? lim : ad_raw);
      aw = $signed(aw_raw);
      span = 0;
      case (cmd)
         CMD_LOAD: begin
            cal_year = ay;
            cal_month = am;
            cal_day = ad;
            cal_wd = (aw >= -1 && aw <= 6) ? aw : -1;
         end
         CMD_INC: begin
            if (int'(cal_day) + 1 > month_len(cal_month, cal_year)) begin
               cal_day = 5'd1;
               if (cal_month >= 4'd12) begin
                  cal_month = 4'd1;
                  cal_year = cal_year + 14'd1;
               end else begin
                  cal_month = cal_month + 4'd1;
               end
            end else begin
               cal_day = cal_day + 5'd1;
            end
            if (cal_wd >= 0) cal_wd = (cal_wd >= 6) ? 4'sd0 : cal_wd + 4'sd1;
         end
         CMD_DEC: begin
            if (cal_day <= 5'd1) begin
               if (cal_month <= 4'd1) begin
                  cal_month = 4'd12;
                  cal_year = cal_year - 14'd1;
               end else begin
                  cal_month = cal_month - 4'd1;
               end
               cal_day = month_len(cal_month, cal_year);
            end else begin
               cal_day = cal_day - 5'd1;
            end
            if (cal_wd >= 0) cal_wd = (cal_wd == 0) ? 4'sd6 : cal_wd - 4'sd1;
         end
         default: begin
            span = day_index(cal_year, cal_month, cal_day) - day_index(ay, am, ad);
            if (span > 4194303) span = 4194303;
            if (span < -4194304) span = -4194304;
         end
      endcase
      r.year = cal_year;
      r.month = cal_month;
      r.day = cal_day;
      r.weekday = cal_wd;
      r.diff = span[22:0];
      return r;
   endfunction

   function automatic cal_row_type mk_row(logic [1:0] c, int y, int m, int d, int w, bit typed,
                                          int ey, int em, int ed, int ew, int ediff);
      cal_row_type r;
      r.cmd = c;
      r.y = y;
      r.m = m;
      r.d = d;
      r.w = w;
      r.typed = typed;
      r.expv.year = ey;
      r.expv.month = em;
      r.expv.day = ed;
      r.expv.weekday = ew;
      r.expv.diff = ediff;
      return r;
   endfunction

   function automatic string show_date(cal_rsp_type r);
      return $sformatf("%0d-%0d-%0d wd %0d diff %0d", r.year, r.month, r.day, r.weekday,
                       r.diff);
   endfunction

   task automatic flag_failure(string msg);
      failures++;
      if (failures <= 10) $display("ERROR: %s", msg);
   endtask

   task automatic send_cmd(input logic [1:0] cmd, input logic [13:0] y, input logic [3:0] m,
                           input logic [4:0] d, input logic [3:0] w, input bit typed,
                           input cal_rsp_type typed_date);
      int          gap;
      cal_rsp_type predicted;
      gap = (((cmds_sent / 100) % 3) == 1) ? 0 : $urandom_range(0, 4);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tuser = cmd;
      req_tdata = {5'd0, w, d, m, y};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      predicted = apply_command(cmd, y, m, d, w);
      pending_dates.push_back(typed ? typed_date : predicted);
      cmds_sent++;
      cmd_count[cmd]++;
   endtask

   // result side
   initial begin
      int          stall;
      cal_rsp_type want, got;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (rsp_beats == HOLD_BEAT) stall = HOLD_CYCLES;
         else if (((rsp_beats / 100) % 3) == 2) stall = 0;
         else stall = $urandom_range(0, 4);
         if (stall > 0) begin
            rsp_tready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         rsp_beats++;
         got.year = rsp_tdata[13:0];
         got.month = rsp_tdata[17:14];
         got.day = rsp_tdata[22:18];
         got.weekday = rsp_tdata[26:23];
         got.diff = rsp_tdata[49:27];
         if (pending_dates.size() == 0) begin
            flag_failure($sformatf("unexpected result beat: %s", show_date(got)));
         end else begin
            want = pending_dates.pop_front();
            if (got.year !== want.year || got.month !== want.month || got.day !== want.day ||
                got.weekday !== want.weekday || got.diff !== want.diff)
               flag_failure($sformatf("beat %0d expected %s got %s", rsp_beats,
                                      show_date(want), show_date(got)));
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timed out after %0d cycles with %0d results outstanding", cycle_count,
               pending_dates.size());
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      logic [1:0]  cmd, dir;
      logic [13:0] y;
      logic [3:0]  m, w;
      logic [4:0]  d;
      int          scen, lim, run, n_dir;
      bit          paused;
      cal_rsp_type no_date;

      no_date = '0;
      paused = 1'b0;

      dir_rows.push_back(mk_row(CMD_DIFF, 1970, 1, 1, 0, 1, 1970, 1, 1, 4, 0));
      dir_rows.push_back(mk_row(CMD_INC, 0, 0, 0, 0, 1, 1970, 1, 2, 5, 0));
      dir_rows.push_back(mk_row(CMD_DEC, 0, 0, 0, 0, 1, 1970, 1, 1, 4, 0));
      dir_rows.push_back(mk_row(CMD_DEC, 0, 0, 0, 0, 1, 1969, 12, 31, 3, 0));
      dir_rows.push_back(mk_row(CMD_LOAD, 16383, 12, 31, 6, 1, 16383, 12, 31, 6, 0));
      dir_rows.push_back(mk_row(CMD_INC, 0, 0, 0, 0, 1, 0, 1, 1, 0, 0));
      dir_rows.push_back(mk_row(CMD_DEC, 0, 0, 0, 0, 1, 16383, 12, 31, 6, 0));
      dir_rows.push_back(mk_row(CMD_LOAD, 0, 2, 28, -1, 1, 0, 2, 28, -1, 0));
      dir_rows.push_back(mk_row(CMD_INC, 0, 0, 0, 0, 1, 0, 2, 29, -1, 0));
      dir_rows.push_back(mk_row(CMD_INC, 0, 0, 0, 0, 1, 0, 3, 1, -1, 0));
      dir_rows.push_back(mk_row(CMD_LOAD, 1900, 2, 29, 7, 1, 1900, 2, 28, -1, 0));
      dir_rows.push_back(mk_row(CMD_LOAD, 2000, 0, 0, -8, 1, 2000, 1, 1, -1, 0));
      dir_rows.push_back(mk_row(CMD_LOAD, 2000, 15, 31, 3, 1, 2000, 12, 31, 3, 0));
      dir_rows.push_back(mk_row(CMD_LOAD, 2000, 2, 31, 2, 1, 2000, 2, 29, 2, 0));
      dir_rows.push_back(mk_row(CMD_INC, 0, 0, 0, 0, 1, 2000, 3, 1, 3, 0));
      dir_rows.push_back(mk_row(CMD_DIFF, 0, 1, 1, 5, 0, 0, 0, 0, 0, 0));
      dir_rows.push_back(mk_row(CMD_DIFF, 2100, 13, 0, 0, 0, 0, 0, 0, 0, 0));
      dir_rows.push_back(mk_row(CMD_LOAD, 0, 1, 1, 0, 1, 0, 1, 1, 0, 0));
      dir_rows.push_back(mk_row(CMD_DIFF, 16383, 12, 31, 0, 1, 0, 1, 1, 0, -4194304));
      dir_rows.push_back(mk_row(CMD_LOAD, 16383, 12, 31, 5, 1, 16383, 12, 31, 5, 0));
      dir_rows.push_back(mk_row(CMD_DIFF, 0, 1, 1, 0, 1, 16383, 12, 31, 5, 4194303));
      dir_rows.push_back(mk_row(CMD_LOAD, 2024, 3, 1, 1, 1, 2024, 3, 1, 1, 0));
      dir_rows.push_back(mk_row(CMD_DEC, 0, 0, 0, 0, 1, 2024, 2, 29, 0, 0));
      dir_rows.push_back(mk_row(CMD_DEC, 0, 0, 0, 0, 1, 2024, 2, 28, 6, 0));
      n_dir = dir_rows.size();

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_rows[i])
         send_cmd(dir_rows[i].cmd, dir_rows[i].y, dir_rows[i].m, dir_rows[i].d, dir_rows[i].w,
                  dir_rows[i].typed, dir_rows[i].expv);

      while (cmds_sent < n_dir + RANDOM_CMDS) begin
         if (!paused && cmds_sent >= n_dir + 350) begin
            // drain everything before going on
            @(negedge clock);
            req_tvalid = 1'b0;
            while (pending_dates.size() != 0) @(negedge clock);
            paused = 1'b1;
         end
         scen = $urandom_range(0, 99);
         if (scen < 30) begin
            // date near a month edge, then a run of steps that may cross it
            case ($urandom_range(0, 5))
               0: y = 14'd0;
               1: y = 14'd16383;
               2: y = 14'd1900;
               3: y = 14'd2000;
               4: y = 14'd2100;
               default: y = $urandom_range(0, 16383);
            endcase
            m = $urandom_range(1, 12);
            lim = month_len(m, y);
            d = $urandom_range(0, 1) ? lim - $urandom_range(0, 2) : $urandom_range(1, 3);
            w = $urandom_range(0, 7) - 1;
            send_cmd(CMD_LOAD, y, m, d, w, 1'b0, no_date);
            run = $urandom_range(1, 8);
            dir = $urandom_range(0, 1) ? CMD_INC : CMD_DEC;
            repeat (run) begin
               if ($urandom_range(0, 4) == 0) cmd = (dir == CMD_INC) ? CMD_DEC : CMD_INC;
               else cmd = dir;
               send_cmd(cmd, $urandom, $urandom, $urandom, $urandom, 1'b0, no_date);
            end
         end else if (scen < 45) begin
            if ($urandom_range(0, 1)) y = cal_year + $urandom_range(0, 4) - 2;
            else y = $urandom_range(0, 16383);
            send_cmd(CMD_DIFF, y, $urandom, $urandom, $urandom, 1'b0, no_date);
         end else if (scen < 55) begin
            send_cmd(CMD_LOAD, $urandom, $urandom, $urandom, $urandom, 1'b0, no_date);
         end else begin
            cmd = $urandom_range(0, 1) ? CMD_INC : CMD_DEC;
            send_cmd(cmd, $urandom, $urandom, $urandom, $urandom, 1'b0, no_date);
         end
      end

      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_dates.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      $display("Checked %0d beats for %0d commands: %0d load, %0d inc, %0d dec, %0d diff.",
               rsp_beats, cmds_sent, cmd_count[CMD_LOAD], cmd_count[CMD_INC],
               cmd_count[CMD_DEC], cmd_count[CMD_DIFF]);
      $display("Ran edge dates, clamping, saturation, a %0d-cycle rsp stall, a drain; %0d failures.",
               HOLD_CYCLES, failures);
      if (failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
